// ===== design/bia_pkg.sv =====
// Shared constants, types and helpers for the bitmap identifier allocator.
// No dependencies; bia_first_free and bitmap_id_allocator import this package.
`timescale 1ns / 1ps

package bia_pkg;

  // Size of the identifier space and the layout of the occupancy store.
  localparam int MAX_IDS   = 4096;
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int LANE_BITS = 8;
  localparam int LANES     = WORD_BITS / LANE_BITS;
  localparam int LANE_W    = $clog2(LANES);
  localparam int WORDS     = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;

  // Field widths of the request and result.
  localparam int FREE_ID_W = 16;
  localparam int GRANT_W   = 13;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int ID_SUM_W  = (WADDR_W + BIT_W + 1 > GRANT_W) ? (WADDR_W + BIT_W + 1) : GRANT_W;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WADDR_W-1:0]   waddr_t;
  typedef logic [BIT_W-1:0]     bitpos_t;

  // Request kinds.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Bits of a word whose identifiers lie within the map; the rest of the
  // last word must never be granted.
  function automatic word_t avail_mask(waddr_t w);
    word_t m;
    int    base;
    base = int'(w) * WORD_BITS;
    for (int k = 0; k < WORD_BITS; k++) begin
      m[k] = (base + k) < MAX_IDS;
    end
    return m;
  endfunction

endpackage

// ===== design/bia_map_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bia_map_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/bia_first_free.sv =====
// Finds the lowest clear bit of one occupancy word, byte first, then bit.
// Depends on bia_pkg.
`timescale 1ns / 1ps

module bia_first_free (
  input  bia_pkg::word_t   occ,
  output logic             found,
  output bia_pkg::bitpos_t pos
);
  import bia_pkg::*;

  logic [LANES-1:0]     lane_free;
  logic [LANE_W-1:0]    lane_sel;
  logic [LANE_BITS-1:0] lane_bits;
  logic [BIT_W-LANE_W-1:0] bit_sel;

  // A lane has room when any of its bits is clear.
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      lane_free[b] = ~&occ[b*LANE_BITS +: LANE_BITS];
    end
  end

  // The lowest lane with room wins.
  always_comb begin
    lane_sel = '0;
    for (int b = LANES - 1; b >= 0; b--) begin
      if (lane_free[b]) begin
        lane_sel = LANE_W'(b);
      end
    end
  end

  // Within that lane, the lowest clear bit wins.
  always_comb begin
    lane_bits = occ[lane_sel*LANE_BITS +: LANE_BITS];
    bit_sel   = '0;
    for (int k = LANE_BITS - 1; k >= 0; k--) begin
      if (!lane_bits[k]) begin
        bit_sel = (BIT_W-LANE_W)'(k);
      end
    end
  end

  assign found = |lane_free;
  assign pos   = {lane_sel, bit_sel};

endmodule

// ===== design/bitmap_id_allocator.sv =====
// Top level of the bitmap identifier allocator: request control, occupancy
// store and result register. Depends on bia_pkg, bia_map_ram, bia_first_free.
`timescale 1ns / 1ps

// First-fit allocator of identifiers 1..MAX_IDS. The occupancy bitmap lives in
// a RAM of 64-bit words, one word read per cycle; identifier n occupies bit
// (n-1) mod 64 of word (n-1)/64, and the lowest free identifier is always
// granted. An allocate request scans the words in order up to the first one
// with room (at most 64 for 4096 identifiers), one word at a time through the
// single read port of the store. A free request reads, modifies and writes back
// its word; an invalid free goes straight to its result. One request is in
// progress at a time, and a new request may be taken while the previous result
// still waits on the output. A flip-flop per word marks it as written, so the
// store reads as empty straight after reset and needs no clearing pass.
module bitmap_id_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] free_id
  input  logic [0:0]  in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [12:0] granted_id, [14:13] status, [15] zero
);
  import bia_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_DONE
  } state_t;

  state_t              state_r;
  op_t                 op_r;
  waddr_t              word_r;
  bitpos_t             bit_r;
  logic [WORDS-1:0]    valid_r;
  logic [GRANT_W-1:0]  res_grant_r;
  status_t             res_status_r;
  logic [GRANT_W-1:0]  out_grant_r;
  status_t             out_status_r;
  logic                out_valid_r;

  logic                rd_en;
  waddr_t              rd_addr;
  word_t               rd_data;
  logic                wr_en;
  word_t               wr_data;
  word_t               cur_word;
  word_t               occ_view;
  logic                ff_found;
  bitpos_t             ff_pos;
  logic                last_word;
  logic                scan_on;
  logic                hand_over;
  logic [FREE_ID_W-1:0] req_idx;
  logic                req_id_ok;
  logic [ID_SUM_W-1:0] grant_sum;

  // Decode of the incoming free identifier.
  assign req_idx   = in_tdata[FREE_ID_W-1:0] - FREE_ID_W'(1);
  assign req_id_ok = (in_tdata[FREE_ID_W-1:0] != '0) &&
                     ({1'b0, in_tdata[FREE_ID_W-1:0]} <= (FREE_ID_W+1)'(MAX_IDS));

  assign in_tready = (state_r == S_IDLE);

  // View of the word just read: unwritten words are empty, bits past the end
  // of the map count as taken.
  assign cur_word  = valid_r[word_r] ? rd_data : '0;
  assign occ_view  = cur_word | ~avail_mask(word_r);
  assign last_word = (word_r == WADDR_W'(WORDS - 1));
  assign grant_sum = ID_SUM_W'({word_r, ff_pos}) + ID_SUM_W'(1);

  bia_first_free u_first_free (
    .occ   (occ_view),
    .found (ff_found),
    .pos   (ff_pos)
  );

  // Read issue: the addressed word, or the next word while scanning, so a
  // scan checks one word every cycle.
  assign scan_on = (state_r == S_CHK) && (op_r == OP_ALLOC) && !ff_found && !last_word;
  assign rd_en   = (state_r == S_RD) || scan_on;
  assign rd_addr = (state_r == S_RD) ? word_r : word_r + WADDR_W'(1);

  // The finished result moves to the output register once that is free.
  assign hand_over = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Write back: set the granted bit, or clear the freed one.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = cur_word;
    if (state_r == S_CHK) begin
      if (op_r == OP_FREE) begin
        wr_en   = 1'b1;
        wr_data = cur_word & ~(word_t'(1) << bit_r);
      end else if (ff_found) begin
        wr_en   = 1'b1;
        wr_data = cur_word | (word_t'(1) << ff_pos);
      end
    end
  end

  bia_map_ram #(
    .DEPTH (WORDS),
    .WIDTH (WORD_BITS),
    .AW    (WADDR_W)
  ) u_map_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (word_r),
    .wr_data (wr_data)
  );

  // Request sequencer with result and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (hand_over) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[word_r] <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r        <= op_t'(in_tuser[0]);
            res_grant_r <= '0;
            if (op_t'(in_tuser[0]) == OP_ALLOC) begin
              word_r  <= '0;
              state_r <= S_RD;
            end else if (req_id_ok) begin
              word_r  <= req_idx[BIT_W +: WADDR_W];
              bit_r   <= req_idx[BIT_W-1:0];
              state_r <= S_RD;
            end else begin
              res_status_r <= ST_INVALID;
              state_r      <= S_DONE;
            end
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (op_r == OP_FREE) begin
            res_status_r <= ST_OK;
            state_r      <= S_DONE;
          end else if (ff_found) begin
            res_grant_r  <= grant_sum[GRANT_W-1:0];
            res_status_r <= ST_OK;
            state_r      <= S_DONE;
          end else if (last_word) begin
            res_status_r <= ST_FULL;
            state_r      <= S_DONE;
          end else begin
            word_r <= word_r + WADDR_W'(1);
          end
        end
        S_DONE: begin
          // Hand over once the output register is free.
          if (hand_over) begin
            out_grant_r  <= res_grant_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_status_r, out_grant_r};

  // A full or invalid result never carries an identifier.
  a_no_grant_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_grant_r == '0))
    else $error("identifier returned with an error status");

  // A write marks its word as holding real data.
  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(word_r)])
    else $error("written word not marked valid");

  // The store is only written while a word is being checked.
  a_write_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_CHK) && !rd_en)
    else $error("store written outside the check step");

endmodule

// ===== bench/bia_grant_checker.sv =====
// Result checker for the bitmap identifier allocator: watches both stream channels,
// keeps its own occupancy bitmap and compares every result with the grant it predicts.
// Depends on bia_pkg for the identifier count, field widths, request kinds and status codes.
`timescale 1ns / 1ps

module bia_grant_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] free_id
  input  logic [0:0]  in_tuser,   // [0] op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [12:0] granted_id, [14:13] status, [15] zero
  output int          mismatch_count,
  output int          grants_outstanding
);
  import bia_pkg::*;

  localparam int         MAP_BYTES = (MAX_IDS + 7) / 8;
  localparam logic [7:0] BYTE_FULL = 8'hFF;
  localparam logic [7:0] TOP_BIT   = 8'h80;

  typedef struct packed {
    logic [GRANT_W-1:0] granted_id;
    status_t            status;
  } grant_t;

  // One occupancy bit per identifier, the lowest identifier of a byte in its top bit.
  logic [7:0] id_occupancy [MAP_BYTES];
  grant_t     grants_due [$];

  // Works out the result of one request and updates the bitmap as the block should.
  task automatic predict_grant(input op_t op, input logic [15:0] ident, output grant_t res);
    bit done;
    int cand;
    int idx;
    res.granted_id = '0;
    res.status     = ST_OK;
    done           = 1'b0;
    if (op == OP_ALLOC) begin
      // First byte with room, then its first clear bit from the top down.
      for (int b = 0; b < MAP_BYTES && !done; b++) begin
        if (id_occupancy[b] != BYTE_FULL) begin
          for (int p = 0; p < 8 && !done; p++) begin
            cand = b * 8 + p + 1;
            if (cand > MAX_IDS) begin
              done = 1'b1;
            end else if ((id_occupancy[b] & (TOP_BIT >> p)) == 8'h00) begin
              id_occupancy[b] = id_occupancy[b] | (TOP_BIT >> p);
              res.granted_id  = cand[GRANT_W-1:0];
              done            = 1'b1;
            end
          end
        end
      end
      if (res.granted_id == '0) begin
        res.status = ST_FULL;
      end
    end else if (ident == 16'd0 || ident > MAX_IDS) begin
      res.status = ST_INVALID;
    end else begin
      // Releasing an identifier that is already free leaves the bit clear and is not flagged.
      idx = int'(ident) - 1;
      id_occupancy[idx >> 3] = id_occupancy[idx >> 3] & ~(TOP_BIT >> (idx & 7));
    end
  endtask

  always @(posedge clk) begin
    grant_t predicted;
    grant_t seen;
    if (!rst_n) begin
      foreach (id_occupancy[b]) id_occupancy[b] = 8'h00;
      grants_due.delete();
      mismatch_count = 0;
    end else begin
      // A result leaving at this edge always belongs to an earlier request.
      if (out_tvalid && out_tready) begin
        seen.granted_id = out_tdata[GRANT_W-1:0];
        seen.status     = status_t'(out_tdata[GRANT_W +: STATUS_W]);
        if (grants_due.size() == 0) begin
          $display("%0t: result with no request outstanding: granted_id %0d status %0d",
                   $time, seen.granted_id, seen.status);
          mismatch_count++;
        end else begin
          predicted = grants_due.pop_front();
          if (seen.granted_id !== predicted.granted_id) begin
            $display("%0t: granted_id mismatch: expected %0d, actual %0d",
                     $time, predicted.granted_id, seen.granted_id);
            mismatch_count++;
          end
          if (seen.status !== predicted.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, predicted.status, seen.status);
            mismatch_count++;
          end
          if (out_tdata[15] !== 1'b0) begin
            $display("%0t: padding bit mismatch: expected 0, actual %b", $time, out_tdata[15]);
            mismatch_count++;
          end
        end
      end
      // A request taken at this edge.
      if (in_tvalid && in_tready) begin
        predict_grant(op_t'(in_tuser[0]), in_tdata, predicted);
        grants_due.push_back(predicted);
      end
    end
    grants_outstanding <= grants_due.size();
  end

endmodule

// ===== bench/tb_bitmap_id_allocator.sv =====
// Testbench top for the bitmap identifier allocator: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on bia_pkg, bitmap_id_allocator and
// bia_grant_checker.
`timescale 1ns / 1ps

module tb_bitmap_id_allocator;
  import bia_pkg::*;

  // The slowest request scans every word of the map; with sender gaps and receiver
  // stalls, over some eighteen hundred requests, the limit leaves several times that.
  localparam int RUN_LIMIT   = 2_000_000;
  localparam int MIXED_ITEMS = 890;
  localparam int DRAIN_WAIT  = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'h0000;  // [15:0] free_id
  logic [0:0]  in_tuser = 1'b0;      // [0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;            // [12:0] granted_id, [14:13] status, [15] zero

  int mismatch_count;
  int grants_outstanding;
  int cycle_count = 0;

  // Sender and receiver pacing state.
  int burst_left  = 0;
  int allocs_sent = 0;
  int stall_left  = 0;
  int rx_mode_left = 0;
  bit rx_steady   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_id_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bia_grant_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_tvalid          (in_tvalid),
    .in_tready          (in_tready),
    .in_tdata           (in_tdata),
    .in_tuser           (in_tuser),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_tdata          (out_tdata),
    .mismatch_count     (mismatch_count),
    .grants_outstanding (grants_outstanding)
  );

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("tb_bitmap_id_allocator: FAIL");
      $finish;
    end
  end

  // Result side: long stretches of steady acceptance alternate with stretches of
  // random stalls.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode_left = $urandom_range(50, 400);
      rx_steady    = ($urandom_range(0, 3) == 0);
    end else begin
      rx_mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 19);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Bursts of random length; between bursts a random gap, sometimes none at all.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Presents one request and returns just after the edge that accepts it.
  task automatic send_request(input op_t op, input logic [15:0] ident);
    pace_sender();
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= ident;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_ALLOC) allocs_sent++;
  endtask

  // Identifier for a free: mostly one in the likely occupied range, now and then
  // zero or any 16-bit value.
  function automatic logic [15:0] pick_free_id(int span);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'($urandom);
    if (roll == 1) return 16'd0;
    return 16'($urandom_range(1, span));
  endfunction

  // A random mix of allocations and frees; alloc_pct sets the balance.
  task automatic mixed_requests(int count, int alloc_pct, bit whole_map);
    int span;
    repeat (count) begin
      span = whole_map ? MAX_IDS : ((allocs_sent + 8 < MAX_IDS) ? allocs_sent + 8 : MAX_IDS);
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_request(OP_ALLOC, 16'($urandom));
      end else begin
        send_request(OP_FREE, pick_free_id(span));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first grants, reuse of a hole, invalid and redundant frees,
    // and the free field being ignored on allocation.
    send_request(OP_ALLOC, 16'h0000);
    send_request(OP_ALLOC, 16'hFFFF);
    send_request(OP_ALLOC, 16'hAAAA);
    send_request(OP_FREE, 16'd2);
    send_request(OP_ALLOC, 16'h5555);
    send_request(OP_FREE, 16'd0);
    send_request(OP_FREE, 16'(MAX_IDS + 1));
    send_request(OP_FREE, 16'hFFFF);
    send_request(OP_FREE, 16'h5555);
    send_request(OP_FREE, 16'(MAX_IDS));
    send_request(OP_FREE, 16'd3);
    send_request(OP_FREE, 16'd3);
    send_request(OP_FREE, 16'd1);
    send_request(OP_ALLOC, 16'h0001);
    send_request(OP_ALLOC, 16'h8000);
    send_request(OP_FREE, 16'd8);
    send_request(OP_FREE, 16'd9);
    send_request(OP_ALLOC, 16'h7FFF);
    send_request(OP_ALLOC, 16'h0000);

    // Churn near the bottom of the map, where the holes cross byte and word borders.
    mixed_requests(MIXED_ITEMS, 65, 1'b0);

    // Allocation-heavy churn with frees anywhere in the map: the map grows and
    // scans run over several words.
    mixed_requests(MIXED_ITEMS, 85, 1'b1);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (grants_outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0 && grants_outstanding == 0) begin
      $display("tb_bitmap_id_allocator: PASS");
    end else begin
      $display("tb_bitmap_id_allocator: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bia_pkg.sv
design/bia_map_ram.sv
design/bia_first_free.sv
design/bitmap_id_allocator.sv
bench/bia_grant_checker.sv
bench/tb_bitmap_id_allocator.sv
